// ----- src/i2c_transfer_sequencer_macros.svh -----
// ============================================================================
// I2C transfer sequencer assertion macros
// Shared clocked assertion forms for the sequencer's port checker.
// ============================================================================
`ifndef I2C_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_TRANSFER_SEQUENCER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define I2CTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define I2CTS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ----- src/i2cts_pkg.sv -----
// ============================================================================
// I2C transfer sequencer package
// Request and result codes, default sizes and stream word layouts.
// ============================================================================
`default_nettype none

package i2cts_pkg;

    // Default storage sizes.
    localparam int MAX_MSGS_DEF = 4;
    localparam int MAX_LEN_DEF  = 16;

    // Seven-bit target address mask.
    localparam logic [6:0] ADDR_MASK = 7'h7f;

    // Request kinds carried in the input tuser.
    typedef enum logic [2:0] {
        REQ_LOAD_DESC = 3'd0,
        REQ_LOAD_BYTE = 3'd1,
        REQ_START     = 3'd2,
        REQ_IRQ       = 3'd3,
        REQ_READ_BACK = 3'd4
    } t_req;

    // Transfer result codes.
    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_NAK  = 2'd1,
        ERR_AL   = 2'd2
    } t_err;

    // Stream word widths.
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 32;

    // Input tdata field offsets.
    localparam int IB_IDX = 0;
    localparam int IB_POS = 2;
    localparam int IB_VAL = 6;
    localparam int IB_DEV = 14;
    localparam int IB_RD  = 21;
    localparam int IB_IGN = 22;
    localparam int IB_NRA = 23;
    localparam int IB_LEN = 24;
    localparam int IB_CNT = 29;
    localparam int IB_STS = 32;

    // Output tdata field offsets.
    localparam int OB_IRQ  = 0;
    localparam int OB_STA  = 1;
    localparam int OB_STO  = 2;
    localparam int OB_WR   = 3;
    localparam int OB_RD   = 4;
    localparam int OB_ACK  = 5;
    localparam int OB_NACK = 6;
    localparam int OB_TX   = 7;
    localparam int OB_DONE = 15;
    localparam int OB_RES  = 16;
    localparam int OB_RB   = 18;

endpackage

`default_nettype wire

// ----- src/i2cts_ram.sv -----
// ============================================================================
// I2C transfer sequencer RAM
// Simple dual-port RAM, one write port and one registered read port.
// ============================================================================
`default_nettype none

module i2cts_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/i2c_transfer_sequencer.sv -----
// ============================================================================
// I2C transfer sequencer
// Drives a byte-level I2C master core through a combined transfer.
// ============================================================================
// Usage: software sends items on the slave stream. The tuser holds the request
// kind (load descriptor, load write byte, start, core interrupt, read back),
// tdata the request fields. Every accepted item yields exactly one result item
// on the master stream with the core command bits, the byte to transmit, the
// done flag with its result code, and read back data.
// Descriptors and write bytes are loaded first, then a start request issues
// the first address byte with START, and each core interrupt issues the next
// command. Between messages a repeated START is issued.
// Pipeline: an accepted item passes the input register, the sequencer step with
// the data RAM read, and the result register.
// Throughput: one item per cycle when not stalled; the data RAM read port is
// used at most once per item and the sequencer state is updated in a single
// step. Stall: when the result register is full and not taken, the whole
// pipeline holds and o_s_axis_tready drops in the same cycle.
// Reset clears the pipeline and the sequencer state. The descriptor table and
// the data RAM are not cleared and must be written before they are used.
// ============================================================================
`default_nettype none

module i2c_transfer_sequencer
    import i2cts_pkg::*;
#(
    parameter int MAX_MSGS = MAX_MSGS_DEF,
    parameter int MAX_LEN  = MAX_LEN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input items.
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata, lowest bit up: msg_index(2) byte_pos(4) byte_value(8) dev_addr(7)
    // is_read(1) ignore_nak(1) no_read_ack(1) msg_len(5) msg_count(3)
    // irq_status(3), zero fill to 40 bits.
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: req_type(3).
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,
    // Result items.
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata, lowest bit up: irq_ack(1) cmd_start(1) cmd_stop(1)
    // cmd_write(1) cmd_read(1) cmd_ack(1) cmd_nack(1) tx_byte(8) done_res(1)
    // result_code(2) read_back(8), zero fill to 32 bits.
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    localparam int MSG_W  = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
    localparam int CNT_W  = $clog2(MAX_MSGS + 1);
    localparam int POS_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int DEPTH  = MAX_MSGS * MAX_LEN;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        PH_RESTART = 4'b0001,
        PH_STOP    = 4'b0010,
        PH_DATA_W  = 4'b0100,
        PH_DATA_R  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [6:0]       addr;
        logic             rd;
        logic             ign;
        logic             nra;
        logic [LEN_W-1:0] len;
    } t_desc;

    // Result of the sequencer step, before the RAM data is merged in.
    typedef struct packed {
        logic       irq;
        logic       sta;
        logic       sto;
        logic       wr;
        logic       rd;
        logic       ack;
        logic       nack;
        logic [7:0] tx;
        logic       tx_ram;
        logic       done;
        t_err       res;
        logic       rb_ram;
    } t_mid;

    // Data RAM address of a message slot and byte position.
    function automatic logic [ADDR_W-1:0] f_addr(input logic [MSG_W-1:0] msg,
                                                 input logic [POS_W-1:0] pos);
        return ADDR_W'(32'(msg) * MAX_LEN + 32'(pos));
    endfunction

    // Pipeline registers.
    logic                  r_in_vld;
    logic [IN_DATA_W-1:0]  r_in_tdata;
    logic [IN_USER_W-1:0]  r_in_tuser;
    logic                  r_mid_vld;
    t_mid                  r_mid;
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_tdata;
    logic [OUT_DATA_W-1:0] n_out_tdata;

    // Sequencer state.
    t_phase           r_phase,     n_phase;
    logic [MSG_W-1:0] r_cur_msg,   n_cur_msg;
    logic [POS_W-1:0] r_cur_pos,   n_cur_pos;
    t_err             r_err,       n_err;
    logic             r_stop_iss,  n_stop_iss;
    logic             r_fin,       n_fin;
    logic [CNT_W-1:0] r_total,     n_total;
    t_desc            r_cur,       n_cur;
    t_desc            r_tbl [MAX_MSGS];

    logic en;
    logic w_fire;

    // Input fields.
    logic [1:0] w_idx;
    logic [3:0] w_pos;
    logic [7:0] w_val;
    logic [6:0] w_dev;
    logic       w_rd;
    logic       w_ign;
    logic       w_nra;
    logic [4:0] w_len;
    logic [2:0] w_cnt;
    logic [2:0] w_sts;
    logic       w_idx_ok;
    logic       w_pos_ok;
    logic [MSG_W-1:0] w_tidx;
    logic [MSG_W-1:0] w_nxt;
    t_desc      w_desc;

    // Step outputs.
    t_mid              w_mid;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [7:0]        w_ram_q;

    // The whole pipeline advances when the result register is free or taken.
    assign en              = ~r_out_vld | i_m_axis_tready;
    assign w_fire          = en & r_in_vld;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_tdata;

    // Field slicing of the registered input item.
    assign w_idx = r_in_tdata[IB_IDX +: 2];
    assign w_pos = r_in_tdata[IB_POS +: 4];
    assign w_val = r_in_tdata[IB_VAL +: 8];
    assign w_dev = r_in_tdata[IB_DEV +: 7];
    assign w_rd  = r_in_tdata[IB_RD];
    assign w_ign = r_in_tdata[IB_IGN];
    assign w_nra = r_in_tdata[IB_NRA];
    assign w_len = r_in_tdata[IB_LEN +: 5];
    assign w_cnt = r_in_tdata[IB_CNT +: 3];
    assign w_sts = r_in_tdata[IB_STS +: 3];

    assign w_idx_ok = 32'(w_idx) < MAX_MSGS;
    assign w_pos_ok = 32'(w_pos) < MAX_LEN;
    assign w_tidx   = MSG_W'(w_idx);
    assign w_nxt    = (32'(r_cur_msg) == MAX_MSGS - 1) ? '0 : r_cur_msg + MSG_W'(1);

    // Descriptor from a load request, with the length saturated.
    always_comb begin
        w_desc.addr = w_dev & ADDR_MASK;
        w_desc.rd   = w_rd;
        w_desc.ign  = w_ign;
        w_desc.nra  = w_nra;
        w_desc.len  = (32'(w_len) > MAX_LEN) ? LEN_W'(MAX_LEN) : LEN_W'(w_len);
    end

    // Sequencer step: one request against the registered state.
    always_comb begin
        t_err             v_err;
        logic             v_fin;
        t_phase           v_ph;
        logic [MSG_W-1:0] v_msg;
        logic [POS_W-1:0] v_pos;
        t_desc            v_m;
        logic             v_last;
        logic             v_stop;
        logic [CNT_W-1:0] v_cnt;

        n_phase    = r_phase;
        n_cur_msg  = r_cur_msg;
        n_cur_pos  = r_cur_pos;
        n_err      = r_err;
        n_stop_iss = r_stop_iss;
        n_fin      = r_fin;
        n_total    = r_total;
        n_cur      = r_cur;
        w_mid      = '0;
        w_mid.res  = ERR_NONE;
        w_we       = 1'b0;
        w_waddr    = f_addr(w_tidx, POS_W'(w_pos));
        w_wdata    = w_val;
        w_raddr    = f_addr(w_tidx, POS_W'(w_pos));
        v_err      = r_err;
        v_fin      = r_fin;
        v_ph       = r_phase;
        v_msg      = r_cur_msg;
        v_pos      = r_cur_pos;
        v_m        = r_cur;
        v_last     = 1'b0;
        v_stop     = 1'b0;
        v_cnt      = '0;

        case (t_req'(r_in_tuser))
            REQ_LOAD_DESC: begin
                if (w_idx_ok && w_tidx == r_cur_msg) begin
                    n_cur = w_desc;
                end
            end
            REQ_LOAD_BYTE: begin
                w_we = w_idx_ok & w_pos_ok;
            end
            REQ_START: begin
                if (w_cnt == 3'd0) begin
                    v_cnt = CNT_W'(1);
                end else if (32'(w_cnt) > MAX_MSGS) begin
                    v_cnt = CNT_W'(MAX_MSGS);
                end else begin
                    v_cnt = CNT_W'(w_cnt);
                end
                n_total    = v_cnt;
                n_cur_msg  = '0;
                n_cur_pos  = '0;
                n_phase    = PH_RESTART;
                n_err      = ERR_NONE;
                n_stop_iss = 1'b0;
                n_fin      = 1'b0;
                n_cur      = r_tbl[0];
                w_mid.sta  = 1'b1;
                w_mid.wr   = 1'b1;
                w_mid.tx   = {r_tbl[0].addr & ADDR_MASK, r_tbl[0].rd};
                if (32'(v_cnt) == 1 && r_tbl[0].len == '0) begin
                    w_mid.sto  = 1'b1;
                    n_stop_iss = 1'b1;
                end
            end
            REQ_IRQ: begin
                if (w_sts[0]) begin
                    w_mid.irq = 1'b1;
                    // Status evaluation: lost arbitration, received byte, NAK.
                    if (w_sts[1]) begin
                        v_err = ERR_AL;
                        v_fin = 1'b1;
                    end else if (r_phase == PH_DATA_R) begin
                        w_we    = 1'b1;
                        w_waddr = f_addr(r_cur_msg, r_cur_pos);
                    end else if (w_sts[2] && !r_cur.ign) begin
                        v_err = ERR_NAK;
                    end
                    n_err = v_err;

                    if (r_stop_iss || v_fin) begin
                        n_fin      = 1'b1;
                        w_mid.done = 1'b1;
                        w_mid.res  = v_err;
                    end else begin
                        // Advance position, message or phase.
                        if (v_err != ERR_NONE) begin
                            v_ph = PH_STOP;
                        end else if (r_phase == PH_RESTART && r_cur.len != '0) begin
                            v_ph = r_cur.rd ? PH_DATA_R : PH_DATA_W;
                        end else if (32'(r_cur_pos) + 32'd1 >= 32'(r_cur.len)) begin
                            if (32'(r_cur_msg) + 32'd1 >= 32'(r_total)) begin
                                v_ph = PH_STOP;
                            end else begin
                                v_pos = '0;
                                v_msg = w_nxt;
                                v_m   = r_tbl[w_nxt];
                                v_ph  = PH_RESTART;
                            end
                        end else begin
                            v_pos = r_cur_pos + POS_W'(1);
                        end

                        v_last = (32'(v_pos) + 32'd1) == 32'(v_m.len);
                        v_stop = v_last && ((32'(v_msg) + 32'd1) == 32'(r_total));

                        // Next core command.
                        case (v_ph)
                            PH_DATA_W: begin
                                w_mid.wr     = 1'b1;
                                w_mid.tx_ram = 1'b1;
                                w_raddr      = f_addr(v_msg, v_pos);
                                if (v_stop) begin
                                    w_mid.sto  = 1'b1;
                                    n_stop_iss = 1'b1;
                                end
                            end
                            PH_DATA_R: begin
                                w_mid.rd = 1'b1;
                                if (v_stop) begin
                                    w_mid.sto  = 1'b1;
                                    n_stop_iss = 1'b1;
                                end
                                if (v_last) begin
                                    w_mid.nack = 1'b1;
                                end else if (!v_m.nra) begin
                                    w_mid.ack = 1'b1;
                                end
                            end
                            PH_RESTART: begin
                                w_mid.sta = 1'b1;
                                w_mid.wr  = 1'b1;
                                w_mid.tx  = {v_m.addr & ADDR_MASK, v_m.rd};
                                if (v_stop && v_m.len == '0) begin
                                    w_mid.sto  = 1'b1;
                                    n_stop_iss = 1'b1;
                                end
                            end
                            default: begin
                                w_mid.sto  = 1'b1;
                                n_stop_iss = 1'b1;
                            end
                        endcase

                        n_phase   = v_ph;
                        n_cur_msg = v_msg;
                        n_cur_pos = v_pos;
                        n_cur     = v_m;
                    end
                end
            end
            REQ_READ_BACK: begin
                w_mid.rb_ram = w_idx_ok & w_pos_ok;
            end
            default: begin
            end
        endcase
    end

    // Control registers: pipeline valids and sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_mid_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_phase    <= PH_RESTART;
            r_cur_msg  <= '0;
            r_cur_pos  <= '0;
            r_err      <= ERR_NONE;
            r_stop_iss <= 1'b0;
            r_fin      <= 1'b0;
            r_total    <= CNT_W'(1);
        end else begin
            if (en) begin
                r_in_vld  <= i_s_axis_tvalid;
                r_mid_vld <= r_in_vld;
                r_out_vld <= r_mid_vld;
            end
            if (w_fire) begin
                r_phase    <= n_phase;
                r_cur_msg  <= n_cur_msg;
                r_cur_pos  <= n_cur_pos;
                r_err      <= n_err;
                r_stop_iss <= n_stop_iss;
                r_fin      <= n_fin;
                r_total    <= n_total;
            end
        end
    end

    // Payload registers and the descriptor table.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_tdata  <= i_s_axis_tdata;
            r_in_tuser  <= i_s_axis_tuser;
            r_mid       <= w_mid;
            r_out_tdata <= n_out_tdata;
        end
        if (w_fire) begin
            r_cur <= n_cur;
        end
        if (w_fire && t_req'(r_in_tuser) == REQ_LOAD_DESC && w_idx_ok) begin
            r_tbl[w_tidx] <= w_desc;
        end
    end

    // Result word: merge the RAM data into the step result.
    always_comb begin
        n_out_tdata               = '0;
        n_out_tdata[OB_IRQ]       = r_mid.irq;
        n_out_tdata[OB_STA]       = r_mid.sta;
        n_out_tdata[OB_STO]       = r_mid.sto;
        n_out_tdata[OB_WR]        = r_mid.wr;
        n_out_tdata[OB_RD]        = r_mid.rd;
        n_out_tdata[OB_ACK]       = r_mid.ack;
        n_out_tdata[OB_NACK]      = r_mid.nack;
        n_out_tdata[OB_TX +: 8]   = r_mid.tx_ram ? w_ram_q : r_mid.tx;
        n_out_tdata[OB_DONE]      = r_mid.done;
        n_out_tdata[OB_RES +: 2]  = r_mid.res;
        n_out_tdata[OB_RB +: 8]   = r_mid.rb_ram ? w_ram_q : 8'h00;
    end

    // Message data bytes: write bytes and received bytes.
    i2cts_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire & w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (en),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

endmodule

`default_nettype wire

// ----- src/i2cts_checker.sv -----
// ============================================================================
// I2C transfer sequencer port checker
// Checks stream behavior and result consistency seen on the top level ports.
// ============================================================================
`default_nettype none

`include "i2c_transfer_sequencer_macros.svh"

module i2cts_checker
    import i2cts_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input wire logic [IN_USER_W-1:0]  i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // A stalled result item stays and keeps its value.
    `I2CTS_ASSERT(a_out_hold, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "stalled result item changed")

    // With an empty result register the block must take input items.
    `I2CTS_ASSERT(a_ready_empty, !o_m_axis_tvalid |-> o_s_axis_tready, "input not ready while output is empty")

    // A done result carries no START, STOP, write or read command.
    `I2CTS_NEVER(a_done_no_cmd, o_m_axis_tvalid && o_m_axis_tdata[OB_DONE] && (o_m_axis_tdata[OB_STA] || o_m_axis_tdata[OB_STO] || o_m_axis_tdata[OB_WR] || o_m_axis_tdata[OB_RD]), "command issued together with done")

    // Ack and nack are never sent on the same byte.
    `I2CTS_NEVER(a_ack_nack, o_m_axis_tvalid && o_m_axis_tdata[OB_ACK] && o_m_axis_tdata[OB_NACK], "ack and nack both set")

    // A result code is only reported with done.
    `I2CTS_NEVER(a_res_done, o_m_axis_tvalid && (o_m_axis_tdata[OB_RES +: 2] != ERR_NONE) && !o_m_axis_tdata[OB_DONE], "result code without done")

endmodule

bind i2c_transfer_sequencer i2cts_checker u_i2cts_checker (.*);

`default_nettype wire
